// ----- rtl/md5h_pkg.sv -----
package md5h_pkg;

    localparam int BLOCK_BYTES_DEF = 64;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic CMD_KEY = 1'b0;
    localparam logic CMD_MSG = 1'b1;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return k[i];
    endfunction

    function automatic logic [4:0] rot_s(input logic [5:0] i);
        logic [4:0] s [16];
        s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
              5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
        return s[{i[5:4], i[1:0]}];
    endfunction

    function automatic logic [3:0] msg_idx(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction

endpackage

// ----- rtl/md5_hmac_hash_engine_core.sv -----
// md5 / hmac-md5 engine
// input beats (s_valid/s_ready) carry either a key word (s_command = 0),
// written to the key store, or a message word (s_command = 1) of
// s_byte_count little-endian bytes; s_last closes the message.
// hmac_enable is sampled at message start and at the last word.
// a message word is merged into the block buffer one byte per cycle while no
// block is being compressed; the next beat is taken only once the word is
// merged. each full 64-byte block adds a compression (ST_RD load, ST_RND at
// one round per cycle, ST_FIN chaining update), with the message word for
// each round read from the block memory in the cycle before that round.
// the last word adds padding and length (1 to 2 blocks), and in hmac mode the
// outer pass (key block, 16 digest bytes and padding: 2 blocks).
// the digest sits in an output register until m_ready; the engine takes no
// further beat until then.
// reset clears chaining values, counts, key store (valid bits) and the
// hmac_enable register; the block buffer needs no clearing.
module md5_hmac_hash_engine_core #(
    parameter int BLOCK_BYTES = md5h_pkg::BLOCK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [3:0]  s_key_index,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_low,
    output logic [63:0] m_digest_high
);
    import md5h_pkg::*;

    localparam int WORDS = BLOCK_BYTES / 4;
    localparam int WB = $clog2(WORDS);
    localparam int FB = $clog2(BLOCK_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE, ST_KEY, ST_MSG, ST_PAD, ST_LEN, ST_OKEY, ST_ODIG,
        ST_RD, ST_RND, ST_FIN, ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        RET_MSG, RET_KEY, RET_PAD, RET_OKEY, RET_ODIG, RET_DONE
    } ret_t;

    state_t state_reg;
    ret_t ret_reg;
    logic hmac_reg, pass_hmac_reg, outer_reg, in_msg_reg;
    logic [31:0] key_mem [16];
    logic [15:0] key_vld_reg;
    logic [31:0] blk_mem [WORDS];
    logic [31:0] blk_rd_reg;
    logic [FB-1:0] fill_reg;
    logic [63:0] mbytes_reg;
    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0] rnd_reg;
    logic [4:0] cnt_reg;
    logic [31:0] word_reg;
    logic [2:0] nb_reg;
    logic last_reg;
    logic [127:0] inner_reg;
    logic [31:0] key_rd_reg;

    // byte write into the block buffer (at most one per cycle)
    logic bw_en;
    logic [7:0] bw_byte;
    logic [WB-1:0] bw_idx;
    logic [31:0] bw_word;
    logic [31:0] cur_word_reg;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid;

    logic [31:0] f_val, sum_val, rot_val;
    always_comb begin
        case (rnd_reg[5:4])
            2'd0: f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            2'd1: f_val = c_reg ^ (d_reg & (b_reg ^ c_reg));
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum_val = a_reg + f_val + round_k(rnd_reg) + blk_rd_reg;
        rot_val = (sum_val << rot_s(rnd_reg)) | (sum_val >> (6'd32 - {1'b0, rot_s(rnd_reg)}));
    end

    logic [WB-1:0] rd_addr;
    always_comb begin
        if (state_reg == ST_RD) rd_addr = WB'(msg_idx(6'd0));
        else rd_addr = WB'(msg_idx(rnd_reg + 6'd1));
    end

    // byte selection per state
    always_comb begin
        bw_en = 1'b0;
        bw_byte = '0;
        case (state_reg)
            ST_MSG: begin bw_en = (nb_reg != 0); bw_byte = word_reg[7:0]; end
            ST_PAD: begin bw_en = 1'b1; bw_byte = (cnt_reg == 0) ? PAD_BYTE : 8'h00; end
            ST_LEN: begin bw_en = 1'b1; bw_byte = 8'((mbytes_reg << 3) >> {cnt_reg[2:0], 3'b000}); end
            ST_KEY: begin
                bw_en = (cnt_reg == 0);
                bw_byte = 8'(key_rd_reg >> {fill_reg[1:0], 3'b000}) ^ (outer_reg ? OPAD : IPAD);
            end
            ST_OKEY: begin
                bw_en = (cnt_reg == 0);
                bw_byte = 8'(key_rd_reg >> {fill_reg[1:0], 3'b000}) ^ OPAD;
            end
            ST_ODIG: begin bw_en = 1'b1; bw_byte = 8'(inner_reg >> {cnt_reg[3:0], 3'b000}); end
            default: ;
        endcase
        bw_idx = fill_reg[FB-1:2];
        bw_word = cur_word_reg;
        case (fill_reg[1:0])
            2'd0: bw_word[7:0] = bw_byte;
            2'd1: bw_word[15:8] = bw_byte;
            2'd2: bw_word[23:16] = bw_byte;
            default: bw_word[31:24] = bw_byte;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (bw_en) blk_mem[bw_idx] <= bw_word;
        blk_rd_reg <= blk_mem[rd_addr];
        if (s_valid && s_ready && s_command == CMD_KEY) key_mem[s_key_index] <= s_data_word;
        key_rd_reg <= key_vld_reg[fill_reg[5:2]] ? key_mem[fill_reg[5:2]] : 32'h0;
    end

    logic block_full;
    assign block_full = bw_en && (fill_reg == FB'(BLOCK_BYTES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg <= RET_MSG;
            hmac_reg <= 1'b0;
            pass_hmac_reg <= 1'b0;
            outer_reg <= 1'b0;
            in_msg_reg <= 1'b0;
            key_vld_reg <= '0;
            fill_reg <= '0;
            mbytes_reg <= '0;
            h_reg <= '{IV_A, IV_B, IV_C, IV_D};
            m_valid <= 1'b0;
            rnd_reg <= '0;
            cnt_reg <= '0;
            cur_word_reg <= '0;
        end else begin
            if (cfg_we) hmac_reg <= cfg_wdata;
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (bw_en) begin
                fill_reg <= fill_reg + 1'b1;
                cur_word_reg <= (fill_reg[1:0] == 2'd3) ? 32'h0 : bw_word;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        if (s_command == CMD_KEY) begin
                            key_vld_reg[s_key_index] <= 1'b1;
                        end else begin
                            word_reg <= s_data_word;
                            nb_reg <= (s_byte_count > 3'd4) ? 3'd4 : s_byte_count;
                            last_reg <= s_last;
                            pass_hmac_reg <= hmac_reg;
                            if (!in_msg_reg) begin
                                in_msg_reg <= 1'b1;
                                h_reg <= '{IV_A, IV_B, IV_C, IV_D};
                                fill_reg <= '0;
                                cur_word_reg <= '0;
                                mbytes_reg <= '0;
                                outer_reg <= 1'b0;
                                if (hmac_reg) begin
                                    state_reg <= ST_KEY;
                                    cnt_reg <= 5'd1;
                                end else state_reg <= ST_MSG;
                            end else state_reg <= ST_MSG;
                        end
                    end
                end
                ST_KEY, ST_OKEY: begin
                    // key byte path reads through the key_rd_reg register; cnt_reg primes it
                    if (cnt_reg != 0) begin
                        cnt_reg <= 5'd0;
                    end
                end
                default: ;
            endcase
            // sequencing of the byte streams
            case (state_reg)
                ST_KEY, ST_OKEY: if (cnt_reg == 0) begin
                    mbytes_reg <= mbytes_reg + 1'b1;
                    if (fill_reg[1:0] == 2'd3) cnt_reg <= 5'd1;
                    if (block_full) begin
                        ret_reg <= (state_reg == ST_OKEY) ? RET_ODIG : RET_MSG;
                        state_reg <= ST_RD;
                    end
                end
                ST_MSG: begin
                    if (nb_reg != 0) begin
                        mbytes_reg <= mbytes_reg + 1'b1;
                        word_reg <= word_reg >> 8;
                        nb_reg <= nb_reg - 1'b1;
                        if (block_full) begin
                            ret_reg <= RET_MSG;
                            state_reg <= ST_RD;
                        end
                    end else if (last_reg) begin
                        cnt_reg <= '0;
                        state_reg <= ST_PAD;
                    end else state_reg <= ST_IDLE;
                end
                ST_PAD: begin
                    if (fill_reg == FB'(BLOCK_BYTES - 9)) begin
                        cnt_reg <= '0;
                        state_reg <= ST_LEN;
                    end else begin
                        cnt_reg <= 5'd1;
                        if (block_full) begin
                            ret_reg <= RET_PAD;
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_LEN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (block_full) begin
                        ret_reg <= RET_DONE;
                        state_reg <= ST_RD;
                    end
                end
                ST_ODIG: begin
                    mbytes_reg <= mbytes_reg + 1'b1;
                    if (cnt_reg == 5'd15) begin
                        cnt_reg <= '0;
                        last_reg <= 1'b1;
                        state_reg <= ST_PAD;
                    end else cnt_reg <= cnt_reg + 1'b1;
                end
                ST_RD: begin
                    rnd_reg <= '0;
                    a_reg <= h_reg[0]; b_reg <= h_reg[1];
                    c_reg <= h_reg[2]; d_reg <= h_reg[3];
                    state_reg <= ST_RND;
                end
                ST_RND: begin
                    a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg;
                    b_reg <= b_reg + rot_val;
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63) state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                    case (ret_reg)
                        RET_MSG: state_reg <= (nb_reg != 0 || last_reg || !outer_reg)
                                              ? ST_MSG : ST_IDLE;
                        RET_PAD: begin cnt_reg <= 5'd1; state_reg <= ST_PAD; end
                        RET_ODIG: begin cnt_reg <= '0; state_reg <= ST_ODIG; end
                        RET_DONE: state_reg <= ST_OUT;
                        default: state_reg <= ST_MSG;
                    endcase
                end
                ST_OUT: begin
                    if (!outer_reg && pass_hmac_reg) begin
                        inner_reg <= {h_reg[3], h_reg[2], h_reg[1], h_reg[0]};
                        outer_reg <= 1'b1;
                        h_reg <= '{IV_A, IV_B, IV_C, IV_D};
                        fill_reg <= '0;
                        cur_word_reg <= '0;
                        mbytes_reg <= '0;
                        cnt_reg <= 5'd1;
                        state_reg <= ST_OKEY;
                    end else begin
                        m_valid <= 1'b1;
                        m_digest_low <= {h_reg[1], h_reg[0]};
                        m_digest_high <= {h_reg[3], h_reg[2]};
                        h_reg <= '{IV_A, IV_B, IV_C, IV_D};
                        fill_reg <= '0;
                        cur_word_reg <= '0;
                        mbytes_reg <= '0;
                        in_msg_reg <= 1'b0;
                        outer_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    a_rounds_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |=> (state_reg == ST_RND && rnd_reg == 6'd0))
        else $error("round start");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("digest dropped");
`endif

endmodule
